FILE: rtl/core/lsu_pkg.sv
// lsu_pkg: shared types and constants for the lifo stack with update unit
// holds request kinds, status codes, control states and port widths
// no dependencies
package lsu_pkg;

  // payload widths
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned POS_W      = 5;
  localparam int unsigned CNT_OUT_W  = 5;
  localparam int unsigned REQ_W      = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned S_TDATA_W  = 40;
  localparam int unsigned M_TDATA_W  = 40;

  // default stack depth
  localparam int unsigned DEPTH_DEF  = 16;

  // request kinds
  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH   = 2'd0,
    REQ_POP    = 2'd1,
    REQ_PEEK   = 2'd2,
    REQ_UPDATE = 2'd3
  } req_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_BAD_DEPTH = 2'd3
  } status_e;

  // control states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_e;

endpackage

FILE: rtl/core/lsu_ram.sv
// lsu_ram: generic single-write, single-read ram with registered read data
// no dependencies
module lsu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/lifo_stack_with_update_unit.sv
// lifo_stack_with_update_unit: push, pop, peek and update-at-depth on a ram stack
// push, update and failed requests give a result in the cycle after transfer;
// successful pop and peek go through the ram read register, then the result register
// 1 request per cycle unless the result side stalls; none while a pop/peek reads the ram
// reset: fill count cleared to empty, control idle, output empty; ram not cleared
// depends on lsu_pkg and lsu_ram
module lifo_stack_with_update_unit
  import lsu_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request side
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [31:0] value_in, [36:32] depth_from_top
  input  logic [REQ_W-1:0]     s_axis_tuser,   // [1:0] req_type
  // result side
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,   // [31:0] value_out, [36:32] count_after
  output logic [STATUS_W-1:0]  m_axis_tuser    // [1:0] status
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

  state_e state_q, state_d;

  logic [CW-1:0]        count_q, count_d;
  logic                 out_valid_q, out_valid_d;
  status_e              out_status_q;
  logic [DATA_W-1:0]    out_value_q;
  logic [CNT_OUT_W-1:0] out_count_q;

  logic                 in_ready;
  logic                 load_rdata;
  logic                 in_xfer;

  req_e                 req;
  logic [DATA_W-1:0]    value_in;
  logic [POS_W-1:0]     pos;
  logic [CMPW-1:0]      cnt_w;
  logic [CMPW-1:0]      pos_w;
  logic [CMPW-1:0]      cnt_after_w;

  status_e              dec_status;
  logic                 dec_wr;
  logic                 dec_rd;
  logic [CMPW-1:0]      dec_addr;
  logic [CW-1:0]        dec_count;

  logic [DATA_W-1:0]    ram_rdata;

  // field unpacking
  assign req      = req_e'(s_axis_tuser);
  assign value_in = s_axis_tdata[DATA_W-1:0];
  assign pos      = s_axis_tdata[DATA_W +: POS_W];
  assign cnt_w    = CMPW'(count_q);
  assign pos_w    = CMPW'(pos);
  assign in_xfer  = s_axis_tvalid && in_ready;

  // request decode against the current fill count
  always_comb begin
    dec_status = ST_OK;
    dec_wr     = 1'b0;
    dec_rd     = 1'b0;
    dec_addr   = cnt_w;
    dec_count  = count_q;
    case (req)
      REQ_PUSH: begin
        if (count_q == CW'(DEPTH)) begin
          dec_status = ST_FULL;
        end else begin
          dec_wr    = 1'b1;
          dec_addr  = cnt_w;
          dec_count = count_q + CW'(1);
        end
      end
      REQ_POP: begin
        if (count_q == '0) begin
          dec_status = ST_EMPTY;
        end else begin
          dec_rd    = 1'b1;
          dec_addr  = cnt_w - CMPW'(1);
          dec_count = count_q - CW'(1);
        end
      end
      REQ_PEEK: begin
        if (count_q == '0) begin
          dec_status = ST_EMPTY;
        end else begin
          dec_rd   = 1'b1;
          dec_addr = cnt_w - CMPW'(1);
        end
      end
      REQ_UPDATE: begin
        if ((pos == '0) || (pos_w > cnt_w)) begin
          dec_status = ST_BAD_DEPTH;
        end else begin
          dec_wr   = 1'b1;
          dec_addr = cnt_w - pos_w;
        end
      end
      default: begin
        dec_status = ST_BAD_DEPTH;
      end
    endcase
  end

  assign cnt_after_w = CMPW'(dec_count);

  // stack storage
  lsu_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (in_xfer && dec_wr),
    .waddr_i (dec_addr[AW-1:0]),
    .wdata_i (value_in),
    .re_i    (in_xfer && dec_rd),
    .raddr_i (dec_addr[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer && dec_rd) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    in_ready   = 1'b0;
    load_rdata = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready = !out_valid_q || m_axis_tready;
      end
      S_READ: begin
        load_rdata = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // fill count and output valid
  always_comb begin
    count_d     = count_q;
    out_valid_d = out_valid_q;
    if (in_xfer) begin
      count_d = dec_count;
    end
    if (in_xfer && !dec_rd) begin
      out_valid_d = 1'b1;
    end else if (load_rdata) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload register
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_status_q <= dec_status;
      out_count_q  <= cnt_after_w[CNT_OUT_W-1:0];
      out_value_q  <= '0;
    end else if (load_rdata) begin
      out_value_q  <= ram_rdata;
    end
  end

  assign s_axis_tready = in_ready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {{(M_TDATA_W - DATA_W - CNT_OUT_W){1'b0}}, out_count_q, out_value_q};

endmodule

FILE: rtl/core/lsu_checker.sv
// lsu_checker: port-level assertions for the lifo stack with update unit
// depends on lsu_pkg; bound to lifo_stack_with_update_unit
module lsu_checker
  import lsu_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [S_TDATA_W-1:0] s_axis_tdata,
  input logic [REQ_W-1:0]     s_axis_tuser,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic [STATUS_W-1:0]  m_axis_tuser
);

  localparam logic [CNT_OUT_W-1:0] FULL_CNT = CNT_OUT_W'(DEPTH);

  // a waiting request stays offered with the same payload
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=>
      s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))
    else $error("request changed while waiting");

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // empty status means nothing is held and no word comes back
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_EMPTY) |->
      (m_axis_tdata[DATA_W +: CNT_OUT_W] == '0) && (m_axis_tdata[DATA_W-1:0] == '0))
    else $error("empty status with nonzero count or data");

  // full status only at the full count
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_FULL) |->
      (m_axis_tdata[DATA_W +: CNT_OUT_W] == FULL_CNT) && (m_axis_tdata[DATA_W-1:0] == '0))
    else $error("full status with wrong count or nonzero data");

  // rejected updates return a zero word
  a_bad_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_BAD_DEPTH) |-> (m_axis_tdata[DATA_W-1:0] == '0))
    else $error("bad depth status with nonzero data");

endmodule

bind lifo_stack_with_update_unit lsu_checker #(
  .DEPTH (DEPTH)
) u_lsu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

FILE: dv/lifo_stack_with_update_unit_test.sv
// lifo_stack_with_update_unit_test: self-checking bench for the lifo stack with update unit
// drives push, pop, peek and update requests through the streaming ports under several idle
// patterns and checks every result against a shadow stack; depends on lsu_pkg and the rtl
module lifo_stack_with_update_unit_test;
  import lsu_pkg::*;

  localparam int unsigned STACK_DEPTH = DEPTH_DEF;
  localparam int unsigned IDLE_LIMIT  = 1000;
  localparam int unsigned PHASE_ITEMS = 100;

  typedef struct packed {
    req_e        kind;
    logic [31:0] word;
    logic [4:0]  pos;
  } stack_req_t;

  typedef struct packed {
    status_e     st;
    logic [31:0] val;
    logic [4:0]  cnt;
  } stack_res_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;   // [31:0] value_in, [36:32] depth_from_top
  logic [REQ_W-1:0]     s_axis_tuser = '0;   // [1:0] req_type
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;        // [31:0] value_out, [36:32] count_after
  logic [STATUS_W-1:0]  m_axis_tuser;        // [1:0] status

  // requests waiting to be driven, results waiting to arrive
  stack_req_t request_q[$];
  stack_res_t answer_q[$];

  // shadow stack
  logic [31:0] shadow_mem [0:STACK_DEPTH-1];
  int          shadow_held = 0;

  int gen_held      = 0;
  int n_added       = 0;
  int n_acc         = 0;
  int n_res         = 0;
  int n_err         = 0;
  int kind_hits[4]  = '{default: 0};
  int stat_hits[4]  = '{default: 0};
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int idle_cycles   = 0;
  logic req_fire    = 1'b0;

  lifo_stack_with_update_unit #(
    .DEPTH(STACK_DEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // apply one request to the shadow stack and return the result it should give
  function automatic stack_res_t stack_apply(stack_req_t rq);
    stack_res_t rs;
    rs.st  = ST_OK;
    rs.val = '0;
    case (rq.kind)
      REQ_PUSH: begin
        if (shadow_held >= STACK_DEPTH) begin
          rs.st = ST_FULL;
        end else begin
          shadow_mem[shadow_held] = rq.word;
          shadow_held++;
        end
      end
      REQ_POP: begin
        if (shadow_held == 0) begin
          rs.st = ST_EMPTY;
        end else begin
          shadow_held--;
          rs.val = shadow_mem[shadow_held];
        end
      end
      REQ_PEEK: begin
        if (shadow_held == 0) begin
          rs.st = ST_EMPTY;
        end else begin
          rs.val = shadow_mem[shadow_held-1];
        end
      end
      default: begin
        // depth 1 is the top entry; zero and anything past the fill level are rejected
        if (rq.pos == 0 || int'(rq.pos) > shadow_held) begin
          rs.st = ST_BAD_DEPTH;
        end else begin
          shadow_mem[shadow_held-int'(rq.pos)] = rq.word;
        end
      end
    endcase
    rs.cnt = 5'(shadow_held);
    kind_hits[rq.kind]++;
    stat_hits[rs.st]++;
    return rs;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on result %0d: %s got 0x%0h, wanted 0x%0h", n_res, what, got, want);
    n_err++;
  endtask

  // queue one request and track the fill level it leads to
  task automatic add_req(req_e k, logic [31:0] w, logic [4:0] p);
    stack_req_t rq;
    rq.kind = k;
    rq.word = w;
    rq.pos  = p;
    request_q.push_back(rq);
    n_added++;
    if (k == REQ_PUSH && gen_held < STACK_DEPTH) gen_held++;
    if (k == REQ_POP && gen_held > 0) gen_held--;
  endtask

  // words lean toward the signed extremes, zero and all ones
  function automatic logic [31:0] rand_word();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [4:0] rand_pos();
    return 5'($urandom_range(STACK_DEPTH));
  endfunction

  // one burst of well-formed or noisy requests
  task automatic gen_burst();
    int   mode;
    int   p;
    req_e k;
    mode = $urandom_range(9);
    if (mode <= 2) begin
      // fill to the top, then hit the full case
      while (gen_held < STACK_DEPTH) add_req(REQ_PUSH, rand_word(), rand_pos());
      repeat ($urandom_range(2, 1)) add_req(REQ_PUSH, rand_word(), rand_pos());
      add_req(REQ_UPDATE, rand_word(), 5'(STACK_DEPTH));
    end else if (mode <= 4) begin
      // drain to empty with peeks mixed in, then hit the empty cases
      while (gen_held > 0) begin
        k = ($urandom_range(3) == 0) ? REQ_PEEK : REQ_POP;
        add_req(k, rand_word(), rand_pos());
      end
      add_req(($urandom_range(1) == 0) ? REQ_PEEK : REQ_POP, rand_word(), rand_pos());
      add_req(REQ_UPDATE, rand_word(), rand_pos());
    end else if (mode <= 7) begin
      // updates mostly at valid depths, read back by peek or pop
      repeat ($urandom_range(8, 2)) begin
        if (gen_held == 0) begin
          add_req(REQ_PUSH, rand_word(), rand_pos());
        end
        case ($urandom_range(9))
          0:       p = 0;
          1:       p = (gen_held < STACK_DEPTH) ? gen_held + 1 : gen_held;
          default: p = $urandom_range(gen_held, 1);
        endcase
        add_req(REQ_UPDATE, rand_word(), 5'(p));
        if ($urandom_range(2) == 0) add_req(REQ_PEEK, rand_word(), rand_pos());
      end
      if ($urandom_range(1) == 0) add_req(REQ_POP, rand_word(), rand_pos());
    end else begin
      // noise
      repeat (6) add_req(req_e'($urandom_range(3)), rand_word(), rand_pos());
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i); while (n_acc != n_added || answer_q.size() != 0);
  endtask

  // request driver and result-side stall
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      if (!s_axis_tvalid || req_fire) begin
        if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          stack_req_t rq;
          rq = request_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {3'b000, rq.pos, rq.word};
          s_axis_tuser  <= rq.kind;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: check results, then predict for the accepted request
  always @(posedge clk_i) begin
    stack_req_t rq;
    stack_res_t want_rs;
    if (!rst_ni) begin
      req_fire <= 1'b0;
    end else begin
      req_fire <= s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        n_res++;
        if (answer_q.size() == 0) begin
          report_mismatch("result with nothing pending", m_axis_tdata[31:0], '0);
        end else begin
          want_rs = answer_q.pop_front();
          if (m_axis_tuser !== want_rs.st)
            report_mismatch("status", 32'(m_axis_tuser), 32'(want_rs.st));
          if (m_axis_tdata[31:0] !== want_rs.val)
            report_mismatch("value_out", m_axis_tdata[31:0], want_rs.val);
          if (m_axis_tdata[36:32] !== want_rs.cnt)
            report_mismatch("count_after", 32'(m_axis_tdata[36:32]), 32'(want_rs.cnt));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        rq.kind = req_e'(s_axis_tuser);
        rq.word = s_axis_tdata[31:0];
        rq.pos  = s_axis_tdata[36:32];
        answer_q.push_back(stack_apply(rq));
        n_acc++;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // stimulus sequence
  initial begin
    int ph;
    int start;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty cases, extremes, update at edge depths
    add_req(REQ_POP,    32'hFFFF_FFFF, 5'd16);
    add_req(REQ_PEEK,   32'h8000_0000, 5'd1);
    add_req(REQ_UPDATE, 32'h1234_5678, 5'd1);
    add_req(REQ_UPDATE, 32'h1234_5678, 5'd0);
    add_req(REQ_UPDATE, 32'hFFFF_FFFF, 5'd16);
    add_req(REQ_PUSH,   32'h7FFF_FFFF, 5'd16);
    add_req(REQ_PUSH,   32'h8000_0000, 5'd0);
    add_req(REQ_PEEK,   32'h0000_0000, 5'd0);
    add_req(REQ_UPDATE, 32'hFFFF_FFFF, 5'd1);
    add_req(REQ_UPDATE, 32'h0000_0000, 5'd2);
    add_req(REQ_UPDATE, 32'h5555_5555, 5'd3);
    add_req(REQ_UPDATE, 32'hAAAA_AAAA, 5'd0);
    add_req(REQ_PEEK,   32'h7FFF_FFFF, 5'd31 & 5'd16);
    add_req(REQ_POP,    32'h0000_0000, 5'd0);
    add_req(REQ_POP,    32'hFFFF_FFFF, 5'd15);
    add_req(REQ_POP,    32'h0000_0000, 5'd0);
    add_req(REQ_PUSH,   32'h0000_0000, 5'd15);
    add_req(REQ_POP,    32'h0000_0000, 5'd0);
    wait_drained();

    // random phases: no idling, sender idle, receiver stall, both
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      start = n_added;
      while (n_added - start < PHASE_ITEMS) gen_burst();
      // sender holds off until every result of the phase is back
      wait_drained();
    end

    repeat (6) @(negedge clk_i);
    if (answer_q.size() != 0)
      report_mismatch("results never arrived", '0, 32'(answer_q.size()));

    $display("ran %0d requests: %0d push, %0d pop, %0d peek, %0d update",
             n_acc, kind_hits[REQ_PUSH], kind_hits[REQ_POP], kind_hits[REQ_PEEK],
             kind_hits[REQ_UPDATE]);
    $display("outcomes: %0d ok, %0d full, %0d empty, %0d bad depth; %0d results checked",
             stat_hits[ST_OK], stat_hits[ST_FULL], stat_hits[ST_EMPTY],
             stat_hits[ST_BAD_DEPTH], n_res);
    if (n_err == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/lsu_pkg.sv
rtl/core/lsu_ram.sv
rtl/core/lifo_stack_with_update_unit.sv
rtl/core/lsu_checker.sv
dv/lifo_stack_with_update_unit_test.sv
